[src/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern search block.
// Used by the channel interfaces, the window matcher and the top level.
package wbps_pkg;

  localparam int unsigned MaxLen     = 16;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LenW       = $clog2(MaxLen + 1);
  localparam int unsigned IdxW       = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgLenW    = 5;
  localparam int unsigned OffsetOutW = 32;

  typedef logic [7:0] byte_t;
  typedef byte_t [MaxLen-1:0] window_t;
  typedef logic [OffsetBits-1:0] count_t;
  typedef logic [OffsetOutW-1:0] offset_t;
  typedef logic [LenW-1:0] len_t;

  localparam count_t CountMax = '1;

  typedef enum logic [1:0] {
    CfgPatLo = 2'd0,
    CfgPatHi = 2'd1,
    CfgLen   = 2'd2,
    CfgWild  = 2'd3
  } cfg_idx_e;

endpackage

[src/wbps_if.sv]
// Valid/ready channel interfaces for the byte input and the search result.
// Depends on wbps_pkg for the byte and offset types.
interface wbps_in_if;
  logic             valid;
  logic             ready;
  wbps_pkg::byte_t  data_byte;
  logic             end_of_buffer;

  modport source(output valid, data_byte, end_of_buffer, input ready);
  modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

interface wbps_out_if;
  logic              valid;
  logic              ready;
  logic              match_found;
  wbps_pkg::offset_t match_offset;

  modport source(output valid, match_found, match_offset, input ready);
  modport sink(input valid, match_found, match_offset, output ready);
endinterface

[src/wildcard_byte_pattern_search_top.sv]
// Top level of the wildcard byte pattern search block.
// Depends on wbps_pkg, wbps_if and wbps_window_match.
//
//  Channel   Direction  Beat contents                     Accepted when
//  byte_i    in         data_byte, end_of_buffer          valid && ready
//  result_o  out        match_found, match_offset         valid && ready
//  cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i   cfg_we_i high
//
// One byte is taken per cycle while the output register does not hold the input
// off. The whole compare for a byte is done in the cycle it is accepted and
// the result lands in the output register, so it shows on result_o in the next cycle.
// The output register separates the two sides: a new byte is accepted whenever
// the register is empty or its result is being taken in the same cycle. Reset clears the
// configuration to its defaults, the window, the byte count and the reported
// flag, and empties the output register.
module wildcard_byte_pattern_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  wbps_in_if.sink                             byte_i,
  wbps_out_if.source                          result_o,
  input  logic                                cfg_we_i,
  input  wbps_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]       cfg_data_i
);

  // Configuration registers.
  logic [63:0]                  pat_lo_q;
  logic [63:0]                  pat_hi_q;
  logic [wbps_pkg::CfgLenW-1:0] len_q;
  wbps_pkg::byte_t              wild_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= wbps_pkg::CfgLenW'(1);
      wild_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbps_pkg::CfgPatLo: pat_lo_q <= cfg_data_i[63:0];
        wbps_pkg::CfgPatHi: pat_hi_q <= cfg_data_i[63:0];
        wbps_pkg::CfgLen:   len_q    <= cfg_data_i[wbps_pkg::CfgLenW-1:0];
        wbps_pkg::CfgWild:  wild_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Pattern bytes in order, byte 0 from the low bits of the low register.
  wbps_pkg::window_t pattern;
  always_comb begin
    for (int j = 0; j < wbps_pkg::MaxLen; j++) begin
      if (j < 8) begin
        pattern[j] = pat_lo_q[8*(j%8) +: 8];
      end else begin
        pattern[j] = pat_hi_q[8*(j%8) +: 8];
      end
    end
  end

  // A length of zero behaves as one, anything beyond the window as the
  // full window.
  wbps_pkg::len_t used_len;
  always_comb begin
    if (len_q == '0) begin
      used_len = wbps_pkg::len_t'(1);
    end else if (32'(len_q) > wbps_pkg::MaxLen) begin
      used_len = wbps_pkg::len_t'(wbps_pkg::MaxLen);
    end else begin
      used_len = wbps_pkg::len_t'(len_q);
    end
  end

  // Per-buffer search state.
  wbps_pkg::window_t win_q, win_d;
  wbps_pkg::count_t  seen_q, seen_d;
  logic              reported_q, reported_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  wbps_pkg::offset_t offset_q, offset_d;

  logic              accept;
  wbps_pkg::window_t win_shift;
  wbps_pkg::count_t  seen_inc;
  logic              enough;
  logic              pat_ok;
  logic              hit;
  logic              has_result;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;

  // The window with the incoming byte shifted in at the newest slot.
  always_comb begin
    win_shift[0] = byte_i.data_byte;
    for (int i = 1; i < wbps_pkg::MaxLen; i++) begin
      win_shift[i] = win_q[i-1];
    end
  end

  // The byte count stops at all ones rather than wrapping.
  assign seen_inc = (seen_q == wbps_pkg::CountMax) ? seen_q
                                                   : seen_q + wbps_pkg::count_t'(1);
  assign enough   = seen_inc >= wbps_pkg::count_t'(used_len);

  wbps_window_match u_match (
    .win_i      (win_shift),
    .pattern_i  (pattern),
    .len_i      (used_len),
    .wildcard_i (wild_q),
    .match_o    (pat_ok)
  );

  assign hit        = !reported_q && enough && pat_ok;
  assign has_result = hit || (!reported_q && byte_i.end_of_buffer);

  // Search state update. Once a match is reported the rest of the buffer is
  // skipped; the final byte of a buffer clears everything for the next one.
  always_comb begin
    win_d      = win_q;
    seen_d     = seen_q;
    reported_d = reported_q;
    if (accept) begin
      if (byte_i.end_of_buffer) begin
        win_d      = '0;
        seen_d     = '0;
        reported_d = 1'b0;
      end else if (!reported_q) begin
        win_d      = win_shift;
        seen_d     = seen_inc;
        reported_d = hit;
      end
    end
  end

  // Output register: loads a result on accept, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    offset_d    = offset_q;
    if (accept && has_result) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      offset_d    = hit ? wbps_pkg::offset_t'(seen_inc - wbps_pkg::count_t'(used_len)) : '0;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.match_found  = found_q;
  assign result_o.match_offset = offset_q;

endmodule

[src/wbps_window_match.sv]
// Parallel wildcard compare of the byte window against the pattern.
// Depends on wbps_pkg for the window type and sizes.
module wbps_window_match (
  input  wbps_pkg::window_t win_i,
  input  wbps_pkg::window_t pattern_i,
  input  wbps_pkg::len_t    len_i,
  input  wbps_pkg::byte_t   wildcard_i,
  output logic              match_o
);

  logic [wbps_pkg::MaxLen-1:0] byte_ok;

  // Pattern byte j lines up with window slot len-1-j (slot 0 is newest).
  always_comb begin
    wbps_pkg::len_t sel;
    for (int j = 0; j < wbps_pkg::MaxLen; j++) begin
      sel = wbps_pkg::len_t'(len_i - wbps_pkg::len_t'(1) - wbps_pkg::len_t'(j));
      if (wbps_pkg::len_t'(j) >= len_i) begin
        byte_ok[j] = 1'b1;
      end else begin
        byte_ok[j] = (pattern_i[j] == wildcard_i) ||
                     (pattern_i[j] == win_i[sel[wbps_pkg::IdxW-1:0]]);
      end
    end
  end

  assign match_o = &byte_ok;

endmodule

[src/wbps_checker.sv]
// Port-level checks for the wildcard byte pattern search top level.
// Bound to wildcard_byte_pattern_search_top; sees its ports only.
module wbps_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_found_i,
  input wbps_pkg::offset_t out_offset_i
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_found_i) && $stable(out_offset_i))
    else $error("result changed while stalled");

  // A result only appears after a byte was accepted.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without an accepted byte");

  // A not-found result always carries offset zero.
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_offset_i == '0)
    else $error("not-found result with nonzero offset");

  // With an empty output register the input is never held off.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_found_i  (result_o.match_found),
  .out_offset_i (result_o.match_offset)
);

[test/wbps_search_checker.sv]
// Scoreboard for the wildcard byte pattern search block: it watches the byte,
// result and register-write ports, predicts every result and compares it.
// Depends on wbps_pkg and the channel interfaces in wbps_if.
module wbps_search_checker
  import wbps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  wbps_in_if                  byte_i,
  wbps_out_if                 result_i,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic    found;
    offset_t offset;
  } search_result_t;

  search_result_t awaited_q[$];

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  byte_t       wild;
  window_t     recent;
  count_t      seen_count;
  logic        reported;

  function automatic byte_t pattern_at(int j);
    return (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
  endfunction

  // Advances the search state by one byte and queues the result it causes.
  function automatic void search_step(byte_t b, logic last);
    int             len;
    logic           hit;
    search_result_t res;
    if (!reported) begin
      len = (pat_len == 0) ? 1 : (pat_len > MaxLen) ? MaxLen : int'(pat_len);
      recent = {recent[MaxLen-2:0], b};
      if (seen_count != CountMax) seen_count++;
      hit = (seen_count >= count_t'(len));
      for (int j = 0; j < len && hit; j++) begin
        if (pattern_at(j) != wild && pattern_at(j) != recent[len-1-j]) hit = 1'b0;
      end
      if (hit) begin
        reported   = 1'b1;
        res.found  = 1'b1;
        res.offset = offset_t'(seen_count - count_t'(len));
        awaited_q.push_back(res);
      end else if (last) begin
        res = '0;
        awaited_q.push_back(res);
      end
    end
    if (last) begin
      recent     = '0;
      seen_count = '0;
      reported   = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t want;
    if (!rst_ni) begin
      pat_lo       = '0;
      pat_hi       = '0;
      pat_len      = 5'd1;
      wild         = '0;
      recent       = '0;
      seen_count   = '0;
      reported     = 1'b0;
      awaited_q.delete();
      fail_count_o = 0;
    end else begin
      // The result leaving now always belongs to an earlier byte.
      if (result_i.valid && result_i.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with nothing awaited: match_found %0b match_offset %0d",
                 result_i.match_found, result_i.match_offset);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (result_i.match_found !== want.found) begin
            $error("match_found expected %0b actual %0b", want.found,
                   result_i.match_found);
            fail_count_o++;
          end
          if (result_i.match_offset !== want.offset) begin
            $error("match_offset expected %0d actual %0d", want.offset,
                   result_i.match_offset);
            fail_count_o++;
          end
        end
      end
      if (byte_i.valid && byte_i.ready) search_step(byte_i.data_byte, byte_i.end_of_buffer);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPatLo: pat_lo = cfg_data_i;
          CfgPatHi: pat_hi = cfg_data_i;
          CfgLen:   pat_len = cfg_data_i[CfgLenW-1:0];
          CfgWild:  wild = cfg_data_i[7:0];
          default:  ;
        endcase
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

[test/wildcard_byte_pattern_search_top_test.sv]
// Testbench top for the wildcard byte pattern search block: drives bytes,
// register writes and result back-pressure, then reports the verdict.
// Depends on wbps_pkg, wbps_if, the block itself and wbps_search_checker.
module wildcard_byte_pattern_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam int RandomPhases   = 14;
  localparam int BytesPerPhase  = 125;
  localparam int CycleLimit     = 300000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  wbps_in_if  byte_ch ();
  wbps_out_if res_ch ();

  wildcard_byte_pattern_search_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_ch),
    .result_o   (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  wbps_search_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_ch),
    .result_i     (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Bytes still to be sent for the buffer in progress. A buffer may run on
  // across a register change, which exercises a change in the middle of a buffer.
  byte_t        scan_q[$];
  // Copy of the current settings, used only to shape the stimulus.
  logic [127:0] cur_pat;
  logic [4:0]   cur_len;
  byte_t        cur_wild;
  // When set, neither side inserts the short random idle cycles; the long result stalls still occur.
  logic         no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every task below is entered just after a falling edge and returns just
  // after one, so all drives happen at falling edges.
  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_buffer <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_buffer();
    byte_t b;
    while (scan_q.size() > 0) begin
      b = scan_q.pop_front();
      send_byte(b, scan_q.size() == 0);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
  endtask

  // Registers change only while the block is idle: the byte input is parked,
  // every awaited result has been taken, and a further wait covers a byte
  // still in flight that causes no result.
  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input byte_t wild);
    byte_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    write_reg(CfgPatLo, lo);
    write_reg(CfgPatHi, hi);
    write_reg(CfgLen, CfgDataW'(len));
    write_reg(CfgWild, CfgDataW'(wild));
    cfg_we   <= 1'b0;
    cur_pat  = {hi, lo};
    cur_len  = len;
    cur_wild = wild;
  endtask

  // Result side: a random hold-off before each beat, and now and then a long
  // stall so that the output register stays full and the byte input backs up
  // while the sender keeps offering bytes. The twenty-first beat always gets one.
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (taken == 20 || $urandom_range(0, 149) == 0) gap = $urandom_range(40, 100);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  // Cycle budget for the whole run; running out of it is a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("wildcard_byte_pattern_search_top test failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    byte_t       wild;
    int          pick;
    int          target;
    int          elen;
    int          n;
    byte_t       b;

    rst_ni                = 1'b0;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_buffer = 1'b0;
    res_ch.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CfgPatLo;
    cfg_data              = '0;
    no_gaps               = 1'b0;
    cur_pat               = '0;
    cur_len               = 5'd1;
    cur_wild              = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Pattern 00, wildcard, FF with length three.
    apply_config(64'h0000_0000_00FF_2A00, 64'h0, 5'd3, 8'h2A);
    // Match that completes on the final byte of the buffer.
    scan_q = '{8'h00, 8'h55, 8'hFF};
    drain_buffer();
    // Buffer shorter than the pattern.
    scan_q = '{8'h00, 8'hFF};
    drain_buffer();
    // Match at offset one; the bytes after it must be ignored.
    scan_q = '{8'h11, 8'h00, 8'h01, 8'hFF, 8'h77, 8'h00};
    drain_buffer();
    // Wildcard byte in the data at a fixed position does not help a mismatch.
    scan_q = '{8'hFF, 8'h2A, 8'h00};
    drain_buffer();
    // Length zero behaves as a one-byte pattern.
    apply_config(64'h0000_0000_0000_00FF, 64'h0, 5'd0, 8'h00);
    scan_q = '{8'h00, 8'hFF};
    drain_buffer();

    // Random part: one register setting per phase, the first few at the edges.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      wild = byte_t'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        // Small alphabet, so matches also turn up in plain noise.
        for (int j = 0; j < 8; j++) begin
          lo[8*j +: 8] = byte_t'($urandom_range(0, 3));
          hi[8*j +: 8] = byte_t'($urandom_range(0, 3));
        end
      end
      for (int j = 0; j < 8; j++) begin
        if ($urandom_range(0, 4) == 0) lo[8*j +: 8] = wild;
        if ($urandom_range(0, 4) == 0) hi[8*j +: 8] = wild;
      end
      pick = $urandom_range(0, 7);
      len  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(1, 16));
      case (phase)
        0: begin
          lo = '1; hi = '1; wild = 8'h00; len = 5'd16;
        end
        1: begin
          lo = '0; hi = '0; wild = 8'hFF; len = 5'd1;
        end
        2: begin
          len = 5'd0;
        end
        3: begin
          // Every pattern byte is the wildcard and the length is above the maximum.
          lo = '1; hi = '1; wild = 8'hFF; len = 5'd31;
        end
        default: ;
      endcase
      apply_config(lo, hi, len, wild);
      no_gaps = (phase % 4 == 3);
      elen = (cur_len == 0) ? 1 : (cur_len > MaxLen) ? MaxLen : int'(cur_len);

      for (int i = 0; i < BytesPerPhase; i++) begin
        if (scan_q.size() == 0) begin
          // Mostly short buffers made of planted matches, broken prefixes of
          // the pattern and noise; now and then a long one.
          target = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 20);
          while (scan_q.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
              n = (pick < 3) ? elen : $urandom_range(0, elen - 1);
              for (int j = 0; j < n; j++) begin
                b = cur_pat[8*j +: 8];
                scan_q.push_back((b == cur_wild) ? byte_t'($urandom) : b);
              end
              if (pick >= 3) scan_q.push_back(cur_pat[8*n +: 8] ^ byte_t'($urandom_range(1, 255)));
            end else begin
              scan_q.push_back(byte_t'($urandom));
            end
          end
        end
        b = scan_q.pop_front();
        send_byte(b, scan_q.size() == 0);
      end
    end
    no_gaps = 1'b0;
    drain_buffer();

    // Let the last results come out, then give the verdict.
    byte_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (5) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("wildcard_byte_pattern_search_top test passed");
    end else begin
      $display("wildcard_byte_pattern_search_top test failed");
    end
    $finish;
  end

endmodule
